// ===== rtl/core/ang_pkg.sv =====
// ----------------------------------------------------------------------------
// Adaptive noise gate package
// Shared widths, register indexes, configuration and queue types, and the
// arithmetic helpers of the level tracking datapath.
// ----------------------------------------------------------------------------
package ang_pkg;

   // Channel count and field widths.
   localparam int CHANNELS   = 8;
   localparam int CH_W       = 3;
   localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SAMPLE_W   = 16;
   localparam int MAG_W      = 16;
   localparam int SQ_W       = 31;
   localparam int LEVEL_W    = 32;
   localparam int COUNT_W    = 20;
   localparam int COEF_W     = 16;
   localparam int THRESH_W   = 31;
   localparam int STEP_W     = 17;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_RMS_COEF   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_COEF = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_LEN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_LEN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_STEP  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BYPASS     = 3'd6;

   // Register values after reset.
   localparam logic [COEF_W-1:0]   RST_RMS_COEF   = 16'd65455;
   localparam logic [COEF_W-1:0]   RST_TRACK_COEF = 16'd65535;
   localparam logic [THRESH_W-1:0] RST_THRESHOLD  = 31'd134217728;
   localparam logic [COUNT_W-1:0]  RST_HOLD_LEN   = 20'd12000;
   localparam logic [COUNT_W-1:0]  RST_RAMP_LEN   = 20'd6000;
   localparam logic [STEP_W-1:0]   RST_RAMP_STEP  = 17'd11;

   // Shared multiplier operand and product widths.
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 18;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   typedef struct packed {
      logic [COEF_W-1:0]   rms_coef;
      logic [COEF_W-1:0]   track_coef;
      logic [THRESH_W-1:0] threshold;
      logic [COUNT_W-1:0]  hold_len;
      logic [COUNT_W-1:0]  ramp_len;
      logic [STEP_W-1:0]   ramp_step;
      logic                bypass;
   } cfg_type;

   // One classified sample waiting for the back.
   typedef struct packed {
      logic [CH_W-1:0]            channel;
      logic signed [SAMPLE_W-1:0] sample;
      logic [MAG_W-1:0]           mag;
      logic [SQ_W-1:0]            sq;
      logic                       in_range;
   } entry_type;

   // Signed difference x - t of two unsigned levels, as a multiplier operand.
   function automatic logic signed [MUL_A_W-1:0] level_diff(
      input logic [LEVEL_W-1:0] x,
      input logic [LEVEL_W-1:0] t
   );
      return $signed({2'b00, x}) - $signed({2'b00, t});
   endfunction

   // Finish a Q16 blend: (t * 65536 + (x - t) * c + 32768) >> 16.
   function automatic logic [LEVEL_W-1:0] blend_finish(
      input logic [LEVEL_W-1:0]       t,
      input logic signed [PROD_W-1:0] prod
   );
      logic signed [PROD_W-1:0] acc;
      acc = $signed({4'b0000, t, 16'h0000}) + prod + $signed(PROD_W'(32768));
      return acc[LEVEL_W+15:16];
   endfunction

endpackage

// ===== rtl/core/adaptive_noise_gate.sv =====
// ----------------------------------------------------------------------------
// Adaptive noise gate
// Per-channel noise gate with level tracking, hold and linear release ramp.
// ----------------------------------------------------------------------------
// Usage:
//  Samples arrive on the req_ channel, each tagged with its channel number
//  in req_tuser; gated samples leave on the rsp_ channel, one per input, in
//  order, with the trigger flag in rsp_tuser.
//  The csr_ port writes one setting per cycle while csr_we is high; write
//  settings only while no transaction is in flight.
//  A sample in its channel's release ramp passes through the extra gain
//  and scale states before the output register is loaded.
//  The back sequencer takes a new sample only once the previous result
//  has been loaded into the output register, and performs every level,
//  floor, ceiling and gain product on one shared multiplier.
//  A two-entry queue decouples input from processing, so new samples are
//  taken while a result waits in the output register.
//  If rsp_tready stays low, the output register and then the queue fill,
//  and req_tready drops.
//  Reset clears all channel levels and counters and loads the default
//  settings, which include bypass.
// ----------------------------------------------------------------------------
module adaptive_noise_gate (
   input  logic                               clock,
   input  logic                               reset,
   // Input stream.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [15:0]                        req_tdata,  // [15:0] sample_in
   input  logic [2:0]                         req_tuser,  // [2:0] channel
   // Result stream.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [15:0]                        rsp_tdata,  // [15:0] sample_out
   output logic [0:0]                         rsp_tuser,  // [0] triggered
   // Settings write port.
   input  logic                               csr_we,
   input  logic [ang_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ang_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ang_pkg::*;

   cfg_type                    cfg_ff, cfg_in;
   logic                       queue_full;
   logic                       push;
   entry_type                  push_entry;
   logic                       pop;
   logic                       pop_valid;
   entry_type                  pop_entry;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic                       rsp_triggered;

   // Settings registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RMS_COEF:   cfg_in.rms_coef   = csr_wdata[COEF_W-1:0];
            CSR_TRACK_COEF: cfg_in.track_coef = csr_wdata[COEF_W-1:0];
            CSR_THRESHOLD:  cfg_in.threshold  = csr_wdata[THRESH_W-1:0];
            CSR_HOLD_LEN:   cfg_in.hold_len   = csr_wdata[COUNT_W-1:0];
            CSR_RAMP_LEN:   cfg_in.ramp_len   = csr_wdata[COUNT_W-1:0];
            CSR_RAMP_STEP:  cfg_in.ramp_step  = csr_wdata[STEP_W-1:0];
            CSR_BYPASS:     cfg_in.bypass     = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rms_coef   <= RST_RMS_COEF;
         cfg_ff.track_coef <= RST_TRACK_COEF;
         cfg_ff.threshold  <= RST_THRESHOLD;
         cfg_ff.hold_len   <= RST_HOLD_LEN;
         cfg_ff.ramp_len   <= RST_RAMP_LEN;
         cfg_ff.ramp_step  <= RST_RAMP_STEP;
         cfg_ff.bypass     <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept and classify.
   ang_front u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_channel (req_tuser),
      .req_sample  ($signed(req_tdata)),
      .queue_full  (queue_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   // Queue between front and back.
   ang_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   // Back: level tracking, gating and result register.
   ang_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .pop_valid     (pop_valid),
      .pop_entry     (pop_entry),
      .pop           (pop),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_sample    (rsp_sample),
      .rsp_triggered (rsp_triggered)
   );

   assign rsp_tdata    = $unsigned(rsp_sample);
   assign rsp_tuser[0] = rsp_triggered;

endmodule

// ===== rtl/core/ang_front.sv =====
// ----------------------------------------------------------------------------
// Adaptive noise gate front
// Accepts sample transactions, checks the channel, and forms the magnitude
// and square of the sample before it enters the queue.
// ----------------------------------------------------------------------------
module ang_front (
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ang_pkg::CH_W-1:0]            req_channel,
   input  logic signed [ang_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                queue_full,
   output logic                                push,
   output ang_pkg::entry_type                  push_entry
);
   import ang_pkg::*;

   logic [MAG_W:0]         neg_wide;
   logic [MAG_W-1:0]       mag;
   logic [2*MAG_W-1:0]     sq_full;

   // Magnitude: the most negative sample gives 32768, which still fits.
   assign neg_wide = (MAG_W+1)'(0) - {req_sample[SAMPLE_W-1], req_sample};
   assign mag      = req_sample[SAMPLE_W-1] ? neg_wide[MAG_W-1:0] : MAG_W'(req_sample);
   assign sq_full  = mag * mag;

   // Handshake with the queue.
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   // Classified entry.
   always_comb begin
      push_entry.channel  = req_channel;
      push_entry.sample   = req_sample;
      push_entry.mag      = mag;
      push_entry.sq       = sq_full[SQ_W-1:0];
      push_entry.in_range = (32'(req_channel) < CHANNELS);
   end

endmodule

// ===== rtl/core/ang_queue.sv =====
// ----------------------------------------------------------------------------
// Adaptive noise gate queue
// Short first-in first-out buffer of classified samples between the front
// and the back.
// ----------------------------------------------------------------------------
module ang_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ang_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output ang_pkg::entry_type pop_entry
);
   import ang_pkg::*;

   entry_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full      = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/ang_back.sv =====
// ----------------------------------------------------------------------------
// Adaptive noise gate back
// Sequencer that updates the per-channel level, floor, ceiling and counters
// through one shared multiplier and drives the result register.
// ----------------------------------------------------------------------------
module ang_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ang_pkg::cfg_type                     cfg,
   input  logic                                 pop_valid,
   input  ang_pkg::entry_type                   pop_entry,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [ang_pkg::SAMPLE_W-1:0]  rsp_sample,
   output logic                                 rsp_triggered
);
   import ang_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b0000000001,
      ST_LVL     = 10'b0000000010,
      ST_LVL_ADD = 10'b0000000100,
      ST_FLR     = 10'b0000001000,
      ST_CEIL    = 10'b0000010000,
      ST_CMP     = 10'b0000100000,
      ST_DEC     = 10'b0001000000,
      ST_GAIN    = 10'b0010000000,
      ST_SCALE   = 10'b0100000000,
      ST_OUT     = 10'b1000000000
   } state_type;

   typedef enum logic [1:0] {
      MODE_PASS = 2'd0,
      MODE_RAMP = 2'd1,
      MODE_MUTE = 2'd2
   } mode_type;

   // Per-channel state.
   logic [LEVEL_W-1:0] level_ff   [CHANNELS];
   logic [LEVEL_W-1:0] floor_ff   [CHANNELS];
   logic [LEVEL_W-1:0] ceiling_ff [CHANNELS];
   logic [COUNT_W-1:0] hold_ff    [CHANNELS];
   logic [COUNT_W-1:0] ramp_ff    [CHANNELS];

   state_type                  state_ff, state_in;
   mode_type                   mode_ff, mode_in;
   logic [CH_W-1:0]            ch_ff, ch_in;
   logic signed [SAMPLE_W-1:0] smp_ff, smp_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic [SQ_W-1:0]            sq_ff, sq_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [LEVEL_W-1:0]         lv_ff, lv_in;
   logic [LEVEL_W-1:0]         fl_ff, fl_in;
   logic [LEVEL_W-1:0]         ce_ff, ce_in;
   logic [COUNT_W-1:0]         rn_ff, rn_in;
   logic                       trig_ff, trig_in;
   logic                       out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0] out_sample_ff, out_sample_in;
   logic                       out_trig_ff, out_trig_in;

   logic [CH_AW-1:0]           idx;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   mul_p;
   logic                       trig_now;
   logic [COUNT_W-1:0]         hold_new;
   logic [COUNT_W-1:0]         ramp_new;
   logic                       st_wr;
   logic [COUNT_W-1:0]         hold_wr;
   logic [COUNT_W-1:0]         ramp_wr;
   logic [PROD_W-1:0]          round_sum;
   logic [PROD_W-17:0]         scaled;
   logic signed [SAMPLE_W-1:0] ramp_sample;

   assign idx = CH_AW'(ch_ff);

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_LVL: begin
            mul_a = level_diff(level_ff[idx], LEVEL_W'(sq_ff));
            mul_b = $signed({2'b00, cfg.rms_coef});
         end
         ST_FLR: begin
            mul_a = level_diff(floor_ff[idx], lv_ff);
            mul_b = $signed({2'b00, cfg.track_coef});
         end
         ST_CEIL: begin
            mul_a = level_diff(ceiling_ff[idx], lv_ff);
            mul_b = $signed({2'b00, cfg.track_coef});
         end
         ST_GAIN: begin
            mul_a = $signed(MUL_A_W'(rn_ff));
            mul_b = $signed({1'b0, cfg.ramp_step});
         end
         ST_SCALE: begin
            // A gain of 2^16 or more saturates any nonzero sample anyway.
            mul_a = (|prod_ff[PROD_W-1:32]) ? $signed(MUL_A_W'(34'h1_0000_0000))
                                            : $signed(MUL_A_W'(prod_ff[31:0]));
            mul_b = $signed({2'b00, mag_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Gate decision from the tracked levels.
   assign trig_now = (ce_ff > fl_ff) && (lv_ff > fl_ff) &&
                     ((lv_ff - fl_ff) > LEVEL_W'(cfg.threshold));
   assign hold_new = trig_now ? cfg.hold_len : hold_ff[idx];
   assign ramp_new = trig_now ? cfg.ramp_len : ramp_ff[idx];

   // Ramp output: round half away from zero, then saturate.
   assign round_sum = $unsigned(prod_ff) + PROD_W'(32768);
   assign scaled    = round_sum[PROD_W-1:16];
   always_comb begin
      if (smp_ff[SAMPLE_W-1]) begin
         ramp_sample = (scaled >= (PROD_W-16)'(32768)) ? $signed(16'h8000)
                                                       : $signed(16'h0000 - scaled[15:0]);
      end else begin
         ramp_sample = (scaled > (PROD_W-16)'(32767)) ? $signed(16'h7fff)
                                                      : $signed(scaled[15:0]);
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      ch_in         = ch_ff;
      smp_in        = smp_ff;
      mag_in        = mag_ff;
      sq_in         = sq_ff;
      prod_in       = prod_ff;
      lv_in         = lv_ff;
      fl_in         = fl_ff;
      ce_in         = ce_ff;
      rn_in         = rn_ff;
      trig_in       = trig_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_sample_in = out_sample_ff;
      out_trig_in   = out_trig_ff;
      pop           = 1'b0;
      st_wr         = 1'b0;
      hold_wr       = hold_new;
      ramp_wr       = ramp_new;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               pop      = 1'b1;
               ch_in    = pop_entry.channel;
               smp_in   = pop_entry.sample;
               mag_in   = pop_entry.mag;
               sq_in    = pop_entry.sq;
               mode_in  = MODE_PASS;
               trig_in  = 1'b0;
               state_in = pop_entry.in_range ? ST_LVL : ST_OUT;
            end
         end
         ST_LVL: begin
            prod_in  = mul_p;
            state_in = ST_LVL_ADD;
         end
         ST_LVL_ADD: begin
            lv_in    = blend_finish(LEVEL_W'(sq_ff), prod_ff);
            state_in = ST_FLR;
         end
         ST_FLR: begin
            prod_in  = mul_p;
            state_in = ST_CEIL;
         end
         ST_CEIL: begin
            fl_in    = (lv_ff > floor_ff[idx]) ? blend_finish(lv_ff, prod_ff) : lv_ff;
            prod_in  = mul_p;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            ce_in    = (lv_ff < ceiling_ff[idx]) ? blend_finish(lv_ff, prod_ff) : lv_ff;
            state_in = ST_DEC;
         end
         ST_DEC: begin
            st_wr    = 1'b1;
            trig_in  = trig_now;
            state_in = ST_OUT;
            if (cfg.bypass) begin
               mode_in = MODE_PASS;
            end else if (hold_new != '0) begin
               hold_wr = hold_new - 1'b1;
               mode_in = MODE_PASS;
            end else if (ramp_new != '0) begin
               ramp_wr  = ramp_new - 1'b1;
               rn_in    = ramp_new;
               mode_in  = MODE_RAMP;
               state_in = ST_GAIN;
            end else begin
               mode_in = MODE_MUTE;
            end
         end
         ST_GAIN: begin
            prod_in  = mul_p;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            prod_in  = mul_p;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Load the result register once it is free or being emptied.
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_trig_in  = trig_ff;
               case (mode_ff)
                  MODE_RAMP: out_sample_in = ramp_sample;
                  MODE_MUTE: out_sample_in = '0;
                  default:   out_sample_in = smp_ff;
               endcase
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      ch_ff         <= ch_in;
      smp_ff        <= smp_in;
      mag_ff        <= mag_in;
      sq_ff         <= sq_in;
      prod_ff       <= prod_in;
      lv_ff         <= lv_in;
      fl_ff         <= fl_in;
      ce_ff         <= ce_in;
      rn_ff         <= rn_in;
      trig_ff       <= trig_in;
      out_sample_ff <= out_sample_in;
      out_trig_ff   <= out_trig_in;
   end

   // Per-channel state write-back.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            level_ff[i]   <= '0;
            floor_ff[i]   <= '0;
            ceiling_ff[i] <= '0;
            hold_ff[i]    <= '0;
            ramp_ff[i]    <= '0;
         end
      end else if (st_wr) begin
         level_ff[idx]   <= lv_ff;
         floor_ff[idx]   <= fl_ff;
         ceiling_ff[idx] <= ce_ff;
         hold_ff[idx]    <= hold_wr;
         ramp_ff[idx]    <= ramp_wr;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_sample    = out_sample_ff;
   assign rsp_triggered = out_trig_ff;

endmodule
